// ===== hw/rtl/wam_pkg.sv =====
package wam_pkg;

    localparam int NUM_DIGITS  = 5;
    localparam int MAX_POS     = NUM_DIGITS + 1;
    localparam int REG_CHARS   = 6;
    localparam int LANE_STAGES = 5;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

    localparam logic [47:0] PAT_RESET = 48'd42;

    localparam logic [1:0] REG_ZONE  = 2'd0;
    localparam logic [1:0] REG_NET   = 2'd1;
    localparam logic [1:0] REG_NODE  = 2'd2;
    localparam logic [1:0] REG_POINT = 2'd3;

    typedef struct packed {
        logic [LANE_STAGES-1:0] en;
    } t_pipe_ctl;

    // floor(v / 10) for 16-bit v via reciprocal multiply
    function automatic logic [15:0] div10(input logic [15:0] v);
        logic [34:0] prod;
        prod = 35'(v) * 35'd52429;
        return prod[34:19];
    endfunction

endpackage

// ===== hw/rtl/wam_in_if.sv =====
interface wam_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] zone_number;
    logic [15:0] net_number;
    logic [15:0] node_number;
    logic [15:0] point_number;

    modport source (
        output valid, zone_number, net_number, node_number, point_number,
        input  ready
    );
    modport sink (
        input  valid, zone_number, net_number, node_number, point_number,
        output ready
    );
endinterface

interface wam_out_if;
    logic       valid;
    logic       ready;
    logic       address_match;
    logic [3:0] part_matches;

    modport source (
        output valid, address_match, part_matches,
        input  ready
    );
    modport sink (
        input  valid, address_match, part_matches,
        output ready
    );
endinterface

// ===== hw/rtl/wildcard_address_matcher.sv =====
// Matches each part of a zone/net/node/point address, written in decimal
// without leading zeros, against its own wildcard pattern ('*' matches the
// rest, '?' and '#' one digit, anything else the digit itself; an empty
// pattern never matches). Four lanes, one per part, each peel one decimal
// digit per pipeline stage over four stages, then match the digit string;
// a merge stage ANDs the four flags into the output register. One request
// is taken every cycle unless the consumer holds the output, the only stall;
// its result passes the lane registers and the output register. Patterns
// live at byte addresses 0, 8, 16 and 24 (zone, net, node, point), reset to
// "*"; users write them only while no request is in flight, unenforced.
module wildcard_address_matcher #(
    parameter int PATTERN_CHARS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wam_in_if.sink            i_req,
    wam_out_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    localparam int STORE_CHARS =
        (PATTERN_CHARS > wam_pkg::REG_CHARS) ? wam_pkg::REG_CHARS : PATTERN_CHARS;
    localparam int PW = 8 * STORE_CHARS;

    // pattern registers
    logic [47:0] r_pat_zone, r_pat_net, r_pat_node, r_pat_point;
    logic        cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_zone  <= wam_pkg::PAT_RESET;
            r_pat_net   <= wam_pkg::PAT_RESET;
            r_pat_node  <= wam_pkg::PAT_RESET;
            r_pat_point <= wam_pkg::PAT_RESET;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                wam_pkg::REG_ZONE:  r_pat_zone  <= pwdata[47:0];
                wam_pkg::REG_NET:   r_pat_net   <= pwdata[47:0];
                wam_pkg::REG_NODE:  r_pat_node  <= pwdata[47:0];
                wam_pkg::REG_POINT: r_pat_point <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            wam_pkg::REG_ZONE:  prdata = 64'(r_pat_zone);
            wam_pkg::REG_NET:   prdata = 64'(r_pat_net);
            wam_pkg::REG_NODE:  prdata = 64'(r_pat_node);
            wam_pkg::REG_POINT: prdata = 64'(r_pat_point);
            default:            prdata = 64'd0;
        endcase
    end

    // pipeline flow control
    logic [wam_pkg::LANE_STAGES-1:0] r_vld;
    logic                            r_ovld;
    logic                            en_out;
    wam_pkg::t_pipe_ctl              ctl;

    assign en_out = !r_ovld || o_rsp.ready;

    always_comb begin
        ctl.en[wam_pkg::LANE_STAGES-1] = !r_vld[wam_pkg::LANE_STAGES-1] || en_out;
        for (int k = wam_pkg::LANE_STAGES - 2; k >= 0; k--) begin
            ctl.en[k] = !r_vld[k] || ctl.en[k+1];
        end
    end

    assign i_req.ready = ctl.en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (ctl.en[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int k = 1; k < wam_pkg::LANE_STAGES; k++) begin
                if (ctl.en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (en_out) begin
                r_ovld <= r_vld[wam_pkg::LANE_STAGES-1];
            end
        end
    end

    // lanes
    logic m_zone, m_net, m_node, m_point;

    wam_lane #(.CHARS(STORE_CHARS)) u_lane_zone (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_number  (i_req.zone_number),
        .i_pattern (r_pat_zone[PW-1:0]),
        .o_match   (m_zone)
    );

    wam_lane #(.CHARS(STORE_CHARS)) u_lane_net (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_number  (i_req.net_number),
        .i_pattern (r_pat_net[PW-1:0]),
        .o_match   (m_net)
    );

    wam_lane #(.CHARS(STORE_CHARS)) u_lane_node (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_number  (i_req.node_number),
        .i_pattern (r_pat_node[PW-1:0]),
        .o_match   (m_node)
    );

    wam_lane #(.CHARS(STORE_CHARS)) u_lane_point (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_number  (i_req.point_number),
        .i_pattern (r_pat_point[PW-1:0]),
        .o_match   (m_point)
    );

    // merge and output register
    logic [3:0] r_part;
    logic       r_all;

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_part <= {m_zone, m_net, m_node, m_point};
            r_all  <= m_zone && m_net && m_node && m_point;
        end
    end

    assign o_rsp.valid         = r_ovld;
    assign o_rsp.address_match = r_all;
    assign o_rsp.part_matches  = r_part;

endmodule

// ===== hw/rtl/wam_lane.sv =====
module wam_lane #(
    parameter int CHARS = 6
) (
    input  logic                   i_clk,
    input  wam_pkg::t_pipe_ctl     i_ctl,
    input  logic [15:0]            i_number,
    input  logic [8*CHARS-1:0]     i_pattern,
    output logic                   o_match
);

    logic [15:0] n_q1, n_q2, n_q3, n_q4;
    logic [12:0] r_q1;
    logic [9:0]  r_q2;
    logic [6:0]  r_q3;
    logic [2:0]  r_q4;
    logic [3:0]  r_dg1;
    logic [7:0]  r_dg2;
    logic [11:0] r_dg3;
    logic [15:0] r_dg4;
    logic        r_match;
    logic        n_match;

    logic [15:0] s2_in, s3_in, s4_in;
    logic [3:0]  n_d0, n_d1, n_d2, n_d3;

    assign s2_in = 16'(r_q1);
    assign s3_in = 16'(r_q2);
    assign s4_in = 16'(r_q3);

    assign n_q1 = wam_pkg::div10(i_number);
    assign n_q2 = wam_pkg::div10(s2_in);
    assign n_q3 = wam_pkg::div10(s3_in);
    assign n_q4 = wam_pkg::div10(s4_in);

    assign n_d0 = 4'(i_number - 16'(n_q1 * 16'd10));
    assign n_d1 = 4'(s2_in - 16'(n_q2 * 16'd10));
    assign n_d2 = 4'(s3_in - 16'(n_q3 * 16'd10));
    assign n_d3 = 4'(s4_in - 16'(n_q4 * 16'd10));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_q1  <= n_q1[12:0];
            r_dg1 <= n_d0;
        end
        if (i_ctl.en[1]) begin
            r_q2  <= n_q2[9:0];
            r_dg2 <= {n_d1, r_dg1};
        end
        if (i_ctl.en[2]) begin
            r_q3  <= n_q3[6:0];
            r_dg3 <= {n_d2, r_dg2};
        end
        if (i_ctl.en[3]) begin
            r_q4  <= n_q4[2:0];
            r_dg4 <= {n_d3, r_dg3};
        end
        if (i_ctl.en[4]) begin
            r_match <= n_match;
        end
    end

    // digit string match, digits LSB first in digs
    logic [7:0][3:0]               digs;
    logic [2:0]                    ndig;
    logic [8*wam_pkg::MAX_POS-1:0] pat_ext;

    assign digs    = {12'd0, {1'b0, r_q4}, r_dg4};
    assign pat_ext = (8*wam_pkg::MAX_POS)'(i_pattern);

    always_comb begin
        if (r_q4 != 3'd0) begin
            ndig = 3'd5;
        end else if (r_dg4[15:12] != 4'd0) begin
            ndig = 3'd4;
        end else if (r_dg4[11:8] != 4'd0) begin
            ndig = 3'd3;
        end else if (r_dg4[7:4] != 4'd0) begin
            ndig = 3'd2;
        end else begin
            ndig = 3'd1;
        end
    end

    always_comb begin
        logic       alive;
        logic [7:0] c;
        logic [2:0] idx;
        alive   = 1'b1;
        n_match = 1'b0;
        for (int i = 0; i < wam_pkg::MAX_POS; i++) begin
            c   = pat_ext[8*i +: 8];
            idx = 3'(ndig - 3'(i) - 3'd1);
            if (alive) begin
                if (3'(i) == ndig) begin
                    n_match = (c == 8'd0) || (c == wam_pkg::CH_STAR);
                    alive   = 1'b0;
                end else if (c == wam_pkg::CH_STAR) begin
                    n_match = 1'b1;
                    alive   = 1'b0;
                end else if (!(c == wam_pkg::CH_QUEST || c == wam_pkg::CH_HASH ||
                               c == {wam_pkg::CH_DIGIT_HI, digs[idx]})) begin
                    n_match = 1'b0;
                    alive   = 1'b0;
                end
            end
        end
    end

    assign o_match = r_match;

endmodule

// ===== dv/testbench.sv =====
module testbench;

    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 100;
    localparam int DRAIN_CYCLES  = 12;

    typedef struct packed {
        logic [15:0] zone_number;
        logic [15:0] net_number;
        logic [15:0] node_number;
        logic [15:0] point_number;
    } t_addr;

    typedef struct packed {
        logic       address_match;
        logic [3:0] part_matches;
    } t_verdict;

    class match_tracker;
        logic [47:0] patterns [4];
        t_verdict    pending_verdicts [$];
        int          errors;

        function new();
            foreach (patterns[k]) patterns[k] = wam_pkg::PAT_RESET;
            errors = 0;
        endfunction

        function void set_pattern(logic [1:0] idx, logic [47:0] pat);
            patterns[idx] = pat;
        endfunction

        function void report_error(string what);
            errors++;
            if (errors <= 10) $display("mismatch: %s", what);
        endfunction

        // decimal digits without leading zeros, matched left to right
        function bit part_hits(logic [15:0] num, logic [47:0] pat);
            logic [7:0] rev [5];
            logic [7:0] c;
            int v, n, i, j;
            v = num;
            n = 0;
            do begin
                rev[n] = 8'h30 + 8'(v % 10);
                v = v / 10;
                n++;
            end while (v != 0 && n < 5);
            i = 0;
            j = 0;
            while (i < n && j < wam_pkg::REG_CHARS && pat[8*j +: 8] != 8'h00) begin
                c = pat[8*j +: 8];
                if (c == wam_pkg::CH_STAR) return 1'b1;
                if (c == wam_pkg::CH_QUEST || c == wam_pkg::CH_HASH || c == rev[n-1-i]) begin
                    i++;
                    j++;
                end else begin
                    return 1'b0;
                end
            end
            if (i < n) return 1'b0;
            if (j >= wam_pkg::REG_CHARS) return 1'b1;
            c = pat[8*j +: 8];
            return (c == 8'h00) || (c == wam_pkg::CH_STAR);
        endfunction

        function void note_request(t_addr a);
            t_verdict v;
            v.part_matches = {part_hits(a.zone_number,  patterns[wam_pkg::REG_ZONE]),
                              part_hits(a.net_number,   patterns[wam_pkg::REG_NET]),
                              part_hits(a.node_number,  patterns[wam_pkg::REG_NODE]),
                              part_hits(a.point_number, patterns[wam_pkg::REG_POINT])};
            v.address_match = &v.part_matches;
            pending_verdicts.push_back(v);
        endfunction

        function void check_result(logic am, logic [3:0] pm);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                report_error($sformatf("result am=%b pm=%b with no request outstanding",
                                       am, pm));
                return;
            end
            want = pending_verdicts.pop_front();
            if (am !== want.address_match)
                report_error($sformatf("address_match exp=%b got=%b",
                                       want.address_match, am));
            if (pm !== want.part_matches)
                report_error($sformatf("part_matches exp=%b got=%b",
                                       want.part_matches, pm));
        endfunction

        function void check_pattern(logic [1:0] idx, logic [63:0] got);
            if (got[47:0] !== patterns[idx])
                report_error($sformatf("pattern %0d readback exp=%h got=%h",
                                       idx, patterns[idx], got[47:0]));
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    wam_in_if  req_if ();
    wam_out_if rsp_if ();

    wildcard_address_matcher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    match_tracker tracker;
    int burst_left;
    int steady_left;
    int idle_cycles = 0;
    int stall_count = 0;
    int stall_mode  = 0;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                tracker.note_request({req_if.zone_number, req_if.net_number,
                                      req_if.node_number, req_if.point_number});
            if (rsp_if.valid && rsp_if.ready)
                tracker.check_result(rsp_if.address_match, rsp_if.part_matches);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // consumer back-pressure, switching pattern every so often
    always @(negedge i_clk) begin
        stall_count++;
        if (stall_count % 97 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: rsp_if.ready = 1'b1;
            1: rsp_if.ready = $urandom_range(0, 1);
            2: rsp_if.ready = ($urandom_range(0, 3) == 0);
            default: rsp_if.ready = ((stall_count % 7) < 3);
        endcase
    end

    task automatic apb_write(logic [1:0] idx, logic [47:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = {16'($urandom()), val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apb_read(logic [1:0] idx, output logic [63:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 3'b000};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic release_request();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_idle();
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic load_patterns(logic [47:0] zp, logic [47:0] np,
                                 logic [47:0] dp, logic [47:0] pp);
        logic [47:0] pats [4];
        logic [63:0] rd;
        pats = '{zp, np, dp, pp};
        release_request();
        wait_idle();
        for (int k = 0; k < 4; k++) begin
            apb_write(2'(k), pats[k]);
            tracker.set_pattern(2'(k), pats[k]);
            apb_read(2'(k), rd);
            tracker.check_pattern(2'(k), rd);
        end
    endtask

    task automatic send_request(t_addr a);
        int gap;
        if (burst_left == 0) begin
            if (steady_left > 0) begin
                gap = 0;
            end else begin
                if ($urandom_range(0, 9) == 0) steady_left = $urandom_range(20, 60);
                gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            end
            if (gap > 0) begin
                @(negedge i_clk);
                req_if.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        req_if.valid        = 1'b1;
        req_if.zone_number  = a.zone_number;
        req_if.net_number   = a.net_number;
        req_if.node_number  = a.node_number;
        req_if.point_number = a.point_number;
        do @(posedge i_clk); while (!req_if.ready);
        burst_left--;
        if (steady_left > 0) steady_left--;
    endtask

    function automatic logic [47:0] pack_pattern(string s);
        logic [47:0] p;
        p = '0;
        for (int k = 0; k < s.len() && k < wam_pkg::REG_CHARS; k++) p[8*k +: 8] = s[k];
        return p;
    endfunction

    function automatic logic [47:0] gen_pattern();
        logic [47:0] p;
        logic [7:0]  c;
        int len, pick;
        case ($urandom_range(0, 11))
            0: return 48'h0;
            1: return 48'hFFFF_FFFF_FFFF;
            2: return {$urandom(), 16'($urandom())};
            3: return wam_pkg::PAT_RESET;
            default: begin
                p = {$urandom(), 16'($urandom())};
                len = $urandom_range(1, wam_pkg::REG_CHARS);
                for (int k = 0; k < wam_pkg::REG_CHARS; k++) begin
                    pick = $urandom_range(0, 15);
                    if (pick < 8)       c = 8'h30 + 8'($urandom_range(0, 9));
                    else if (pick < 10) c = wam_pkg::CH_QUEST;
                    else if (pick < 12) c = wam_pkg::CH_HASH;
                    else if (pick < 14) c = wam_pkg::CH_STAR;
                    else                c = 8'($urandom_range(1, 255));
                    if (k < len)       p[8*k +: 8] = c;
                    else if (k == len) p[8*k +: 8] = 8'h00;
                end
                return p;
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_number(logic [47:0] pat);
        logic [7:0] c;
        int v, n, lo, hi;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                // fill the pattern's wildcards with random digits
                v = 0;
                for (int k = 0; k < wam_pkg::REG_CHARS; k++) begin
                    c = pat[8*k +: 8];
                    if (c == 8'h00) break;
                    if (c == wam_pkg::CH_STAR) begin
                        repeat ($urandom_range(0, 2)) v = v * 10 + $urandom_range(0, 9);
                        break;
                    end
                    if (c >= 8'h30 && c <= 8'h39) v = v * 10 + (c - 8'h30);
                    else                         v = v * 10 + $urandom_range(0, 9);
                end
                return 16'(v);
            end
            5, 6: begin
                n  = $urandom_range(1, 5);
                lo = (n == 1) ? 0 : 10 ** (n - 1);
                hi = (10 ** n) - 1;
                if (hi > 65535) hi = 65535;
                return 16'($urandom_range(hi, lo));
            end
            7: begin
                case ($urandom_range(0, 5))
                    0: return 16'd0;
                    1: return 16'd65535;
                    2: return 16'd9;
                    3: return 16'd10;
                    4: return 16'd9999;
                    default: return 16'd10000;
                endcase
            end
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        t_addr a;
        tracker      = new();
        burst_left   = 0;
        steady_left  = 0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_if.valid = 1'b0;
        req_if.zone_number  = '0;
        req_if.net_number   = '0;
        req_if.node_number  = '0;
        req_if.point_number = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset patterns: everything matches
        send_request({16'd0, 16'd0, 16'd0, 16'd0});
        send_request({16'd65535, 16'd65535, 16'd65535, 16'd65535});
        send_request({16'd9, 16'd10, 16'd99, 16'd100});

        // exact digits, one-digit wildcards, trailing star, empty pattern
        load_patterns(pack_pattern("65535"), pack_pattern("?#"),
                      pack_pattern("1*"), 48'h0);
        send_request({16'd65535, 16'd42, 16'd1, 16'd0});
        send_request({16'd65534, 16'd7, 16'd199, 16'd5});
        send_request({16'd6553, 16'd99, 16'd10, 16'd65535});
        send_request({16'd0, 16'd10, 16'd21, 16'd1});

        // all-ones bytes, bytes after the terminator, six-char pattern ending in star
        load_patterns(48'hFFFF_FFFF_FFFF, pack_pattern("0"),
                      pack_pattern("1") | (48'h3939 << 16), pack_pattern("12345*"));
        send_request({16'd255, 16'd0, 16'd1, 16'd12345});
        send_request({16'd0, 16'd1, 16'd19, 16'd1234});
        send_request({16'd65535, 16'd0, 16'd1, 16'd12346});

        // full-width wildcards and a non-digit character
        load_patterns(pack_pattern("??????"), pack_pattern("#####"),
                      pack_pattern("3a"), pack_pattern("*"));
        send_request({16'd12345, 16'd10000, 16'd3, 16'd0});
        send_request({16'd1, 16'd65535, 16'd31, 16'd7});
        send_request({16'd34463, 16'd9999, 16'd30, 16'd65535});

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            load_patterns(gen_pattern(), gen_pattern(), gen_pattern(), gen_pattern());
            repeat (PHASE_ITEMS) begin
                a.zone_number  = pick_number(tracker.patterns[wam_pkg::REG_ZONE]);
                a.net_number   = pick_number(tracker.patterns[wam_pkg::REG_NET]);
                a.node_number  = pick_number(tracker.patterns[wam_pkg::REG_NODE]);
                a.point_number = pick_number(tracker.patterns[wam_pkg::REG_POINT]);
                send_request(a);
            end
        end

        release_request();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
